@@ sv/atpr_pkg.sv @@
// shared types and constants for the adaptive threshold peak rate block
package atpr_pkg;

    localparam int SMP_W      = 16;            // signed input sample
    localparam int AMP_W      = 31;            // squared amplitude, q1.30
    localparam int POS_W      = 12;            // position, wraps at 4096
    localparam int RATE_W     = 16;            // rate in tenths of bpm
    localparam int RING_DEPTH = 5;
    localparam int PTR_W      = 3;
    localparam int ACC_W      = 33;            // sum of five amplitudes
    localparam int ALU_W      = ACC_W + 1;     // shared adder with carry out
    localparam int CNT_W      = 6;             // sequencer step counter

    // 4 * 60 * 10 * sample rate of 1200
    localparam int RATE_NUM_W = 22;
    localparam logic [RATE_NUM_W-1:0] RATE_NUM = RATE_NUM_W'(2880000);

    // divide by ten steps, counted down: seed, three folds, two subtracts, fix-up
    localparam logic [CNT_W-1:0]  THR_ST_SEED   = CNT_W'(7);
    localparam logic [CNT_W-1:0]  THR_ST_FOLD4  = CNT_W'(6);
    localparam logic [CNT_W-1:0]  THR_ST_FOLD8  = CNT_W'(5);
    localparam logic [CNT_W-1:0]  THR_ST_FOLD16 = CNT_W'(4);
    localparam logic [CNT_W-1:0]  THR_ST_SUB8   = CNT_W'(3);
    localparam logic [CNT_W-1:0]  THR_ST_SUB2   = CNT_W'(2);
    localparam logic [CNT_W-1:0]  THR_ST_FIX    = CNT_W'(1);
    localparam logic [CNT_W-1:0]  THR_STEPS     = THR_ST_SEED;
    // largest remainder of a division by ten
    localparam logic [ACC_W-1:0]  THR_REM_MAX   = ACC_W'(9);

    localparam logic [CNT_W-1:0]  RATE_STEPS    = CNT_W'(RATE_NUM_W);
    localparam logic [PTR_W-1:0]  RING_LAST     = PTR_W'(RING_DEPTH - 1);
    localparam logic [RATE_W-1:0] RATE_MAX      = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SUM,
        ST_THR,
        ST_SPAN,
        ST_DIV_RATE,
        ST_OUT
    } atpr_state_t;

endpackage

@@ sv/adaptive_threshold_peak_rate_top.sv @@
// adaptive threshold peak detector with beat rate estimate, single module
// one input beat at a time: in_ready is high only in idle; a beat with a peak runs on one
//   shared 34-bit adder: ring sum (5 steps), divide by ten by shift-add (7 steps), rate
//   constant over span (22 steps, skipped on zero span); a stalled output holds off the next beat
// reset: rst_n asynchronous active low, clears history, rings, threshold and rate
module adaptive_threshold_peak_rate_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [atpr_pkg::SMP_W-1:0] sample,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           peak_found,
    output logic [atpr_pkg::AMP_W-1:0]     peak_amplitude,
    output logic [atpr_pkg::POS_W-1:0]     peak_position,
    output logic [atpr_pkg::AMP_W-1:0]     current_threshold,
    output logic [atpr_pkg::RATE_W-1:0]    rate_tenths_bpm
);
    import atpr_pkg::*;

    // sequencer
    atpr_state_t state_reg, state_next;

    // detector history
    logic [AMP_W-1:0]  cur_reg;        // square of the newest sample
    logic [AMP_W-1:0]  prev_reg;
    logic [AMP_W-1:0]  older_reg;
    logic [POS_W-1:0]  pos_cnt_reg;
    logic [AMP_W-1:0]  thr_reg;
    logic [RATE_W-1:0] rate_reg;

    // rings of the last five peaks
    logic [AMP_W-1:0]  amp_ring_reg [RING_DEPTH];
    logic [POS_W-1:0]  pos_ring_reg [RING_DEPTH];
    logic [PTR_W-1:0]  ptr_reg;
    logic [PTR_W-1:0]  ptr_inc;

    // per item working registers
    logic              found_reg;
    logic [AMP_W-1:0]  peak_amp_reg;
    logic [POS_W-1:0]  peak_pos_reg;
    logic [PTR_W-1:0]  sum_idx_reg;
    logic [ACC_W-1:0]  sum_reg;        // ring sum, then remainder of the divide by ten
    logic [ACC_W-1:0]  quo_reg;        // estimate of 0.8 * sum, then dividend / quotient shifter
    logic [POS_W-1:0]  rem_reg;
    logic [POS_W-1:0]  div_reg;
    logic [CNT_W-1:0]  cnt_reg;

    // output register
    logic              out_valid_reg;
    logic              found_out_reg;
    logic [AMP_W-1:0]  amp_out_reg;
    logic [POS_W-1:0]  pos_out_reg;
    logic [AMP_W-1:0]  thr_out_reg;
    logic [RATE_W-1:0] rate_out_reg;

    // shared adder
    logic [ACC_W-1:0]  alu_a;
    logic [ACC_W-1:0]  alu_b;
    logic              alu_cin;
    logic [ALU_W-1:0]  alu_res;

    logic [SMP_W-1:0]   mag;
    logic [2*SMP_W-1:0] sq_full;
    logic [POS_W:0]     trial;
    logic               no_borrow;
    logic               is_peak;
    logic [POS_W-1:0]   span;
    logic               out_free;
    logic               in_fire;

    // square of the incoming sample, magnitude of -32768 reads as 32768
    assign mag     = sample[SMP_W-1] ? (SMP_W'(0) - sample) : sample;
    assign sq_full = mag * mag;

    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // peak test on the previous square; the newest square must clear the threshold of the last peak
    assign is_peak = (cur_reg > thr_reg) && (prev_reg > older_reg) && (prev_reg > cur_reg);

    assign ptr_inc = (ptr_reg == RING_LAST) ? '0 : ptr_reg + PTR_W'(1);

    // wrapped span from the oldest stored position to the newest
    assign span = peak_pos_reg - pos_ring_reg[ptr_reg];

    // restoring division step: shift the next dividend bit into the remainder
    assign trial     = {rem_reg, quo_reg[ACC_W-1]};
    assign no_borrow = alu_res[ALU_W-1];
    assign alu_res   = {1'b0, alu_a} + {1'b0, alu_b} + ALU_W'(alu_cin);

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        alu_a      = '0;
        alu_b      = '0;
        alu_cin    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = is_peak ? ST_SUM : ST_OUT;
            end
            ST_SUM:
            begin
                alu_a = sum_reg;
                alu_b = ACC_W'(amp_ring_reg[sum_idx_reg]);
                if (sum_idx_reg == RING_LAST)
                begin
                    state_next = ST_THR;
                end
            end
            ST_THR:
            begin
                // sum / 10: estimate 0.8 * sum by shift-add, take an eighth,
                // then fix it up by one from the remainder
                case (cnt_reg)
                    THR_ST_SEED:
                    begin
                        alu_a = {1'b0, sum_reg[ACC_W-1:1]};
                        alu_b = {2'b00, sum_reg[ACC_W-1:2]};
                    end
                    THR_ST_FOLD4:
                    begin
                        alu_a = quo_reg;
                        alu_b = {4'h0, quo_reg[ACC_W-1:4]};
                    end
                    THR_ST_FOLD8:
                    begin
                        alu_a = quo_reg;
                        alu_b = {8'h00, quo_reg[ACC_W-1:8]};
                    end
                    THR_ST_FOLD16:
                    begin
                        alu_a = quo_reg;
                        alu_b = {16'h0000, quo_reg[ACC_W-1:16]};
                    end
                    THR_ST_SUB8:
                    begin
                        alu_a   = sum_reg;
                        alu_b   = ~{quo_reg[ACC_W-1:3], 3'b000};
                        alu_cin = 1'b1;
                    end
                    THR_ST_SUB2:
                    begin
                        alu_a   = sum_reg;
                        alu_b   = ~{2'b00, quo_reg[ACC_W-1:3], 1'b0};
                        alu_cin = 1'b1;
                    end
                    THR_ST_FIX:
                    begin
                        alu_a   = {3'b000, quo_reg[ACC_W-1:3]};
                        alu_cin = (sum_reg > THR_REM_MAX);
                    end
                    default:
                    begin
                    end
                endcase
                if (cnt_reg == THR_ST_FIX)
                begin
                    state_next = ST_SPAN;
                end
            end
            ST_SPAN:
            begin
                state_next = (span == '0) ? ST_OUT : ST_DIV_RATE;
            end
            ST_DIV_RATE:
            begin
                alu_a   = ACC_W'(trial);
                alu_b   = ~ACC_W'(div_reg);
                alu_cin = 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // detector state, rings and the output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= '0;
            older_reg     <= '0;
            pos_cnt_reg   <= '0;
            thr_reg       <= '0;
            rate_reg      <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < RING_DEPTH; i++)
            begin
                amp_ring_reg[i] <= '0;
                pos_ring_reg[i] <= '0;
            end
        end
        else
        begin
            // a new result beat replaces the one taken at this edge
            if ((state_reg == ST_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CHECK:
                begin
                    if (is_peak)
                    begin
                        amp_ring_reg[ptr_reg] <= prev_reg;
                        pos_ring_reg[ptr_reg] <= pos_cnt_reg - POS_W'(1);
                    end
                    older_reg   <= prev_reg;
                    prev_reg    <= cur_reg;
                    pos_cnt_reg <= pos_cnt_reg + POS_W'(1);
                end
                ST_THR:
                begin
                    if (cnt_reg == THR_ST_FIX)
                    begin
                        thr_reg <= alu_res[AMP_W-1:0];
                        ptr_reg <= ptr_inc;
                    end
                end
                ST_DIV_RATE:
                begin
                    if (cnt_reg == CNT_W'(1))
                    begin
                        // the first RATE_NUM_W-1 quotient bits sit in the low bits, the last one is no_borrow
                        if (quo_reg[RATE_NUM_W-2:RATE_W-1] != '0)
                        begin
                            rate_reg <= RATE_MAX;
                        end
                        else
                        begin
                            rate_reg <= {quo_reg[RATE_W-2:0], no_borrow};
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // working and output payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cur_reg <= sq_full[AMP_W-1:0];
        end
        case (state_reg)
            ST_CHECK:
            begin
                found_reg    <= is_peak;
                peak_amp_reg <= is_peak ? prev_reg : '0;
                peak_pos_reg <= is_peak ? (pos_cnt_reg - POS_W'(1)) : '0;
                sum_reg      <= '0;
                sum_idx_reg  <= '0;
            end
            ST_SUM:
            begin
                sum_reg     <= alu_res[ACC_W-1:0];
                sum_idx_reg <= sum_idx_reg + PTR_W'(1);
                cnt_reg     <= THR_STEPS;
            end
            ST_THR:
            begin
                case (cnt_reg)
                    THR_ST_SEED, THR_ST_FOLD4, THR_ST_FOLD8, THR_ST_FOLD16:
                    begin
                        quo_reg <= alu_res[ACC_W-1:0];
                    end
                    THR_ST_SUB8, THR_ST_SUB2:
                    begin
                        sum_reg <= alu_res[ACC_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            ST_DIV_RATE:
            begin
                rem_reg <= no_borrow ? alu_res[POS_W-1:0] : trial[POS_W-1:0];
                quo_reg <= {quo_reg[ACC_W-2:0], no_borrow};
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            ST_SPAN:
            begin
                // dividend left aligned so the quotient lands in the low bits
                quo_reg <= {RATE_NUM, (ACC_W-RATE_NUM_W)'(0)};
                rem_reg <= '0;
                div_reg <= span;
                cnt_reg <= RATE_STEPS;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    found_out_reg <= found_reg;
                    amp_out_reg   <= peak_amp_reg;
                    pos_out_reg   <= peak_pos_reg;
                    thr_out_reg   <= thr_reg;
                    rate_out_reg  <= rate_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid         = out_valid_reg;
    assign peak_found        = found_out_reg;
    assign peak_amplitude    = amp_out_reg;
    assign peak_position     = pos_out_reg;
    assign current_threshold = thr_out_reg;
    assign rate_tenths_bpm   = rate_out_reg;

endmodule

@@ sim/tb_top.sv @@
// self-checking testbench for the adaptive threshold peak rate block
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import atpr_pkg::*;

    // run sizing
    localparam int          RAND_ITEMS  = 1000;   // random beats after the directed table
    localparam int          QUIET_LEN   = 250;    // low-level stretch, gives long spans
    localparam int          DRAIN_TAIL  = 80;     // idle tail for stray beats after the drain
    localparam int unsigned TIMEOUT_NS  = 20_000_000;

    // 4 * 60 * 10 * 1200 samples per second
    localparam longint      BPM_NUMERATOR = 64'd2880000;
    localparam longint      RATE_CEIL     = 64'd65535;

    // one result beat
    typedef struct packed {
        logic              found;
        logic [AMP_W-1:0]  amp;
        logic [POS_W-1:0]  pos;
        logic [AMP_W-1:0]  thr;
        logic [RATE_W-1:0] rate;
    } beat_t;

    // one row of the directed table, want is used only when typed_ok is set
    typedef struct {
        logic signed [SMP_W-1:0] smp;
        bit                      typed_ok;
        beat_t                   want;
    } stim_row_t;

    // receiver stall patterns
    typedef enum int {
        RX_FREE,
        RX_RANDOM,
        RX_EVERY_THIRD,
        RX_SPARSE
    } rx_mode_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic signed [SMP_W-1:0]  sample;
    logic                     out_valid;
    logic                     out_ready;
    logic                     peak_found;
    logic [AMP_W-1:0]         peak_amplitude;
    logic [POS_W-1:0]         peak_position;
    logic [AMP_W-1:0]         current_threshold;
    logic [RATE_W-1:0]        rate_tenths_bpm;

    adaptive_threshold_peak_rate_top u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .sample            (sample),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .peak_found        (peak_found),
        .peak_amplitude    (peak_amplitude),
        .peak_position     (peak_position),
        .current_threshold (current_threshold),
        .rate_tenths_bpm   (rate_tenths_bpm)
    );

    // detector shadow state, mirrors what the block should hold
    logic [AMP_W-1:0]  prev_sq;
    logic [AMP_W-1:0]  older_sq;
    logic [POS_W-1:0]  pos_cnt;
    logic [AMP_W-1:0]  thr_lvl;
    logic [AMP_W-1:0]  amp_ring [RING_DEPTH];
    logic [POS_W-1:0]  pos_ring [RING_DEPTH];
    int                ring_idx;
    logic [RATE_W-1:0] bpm_rate;

    // results still owed by the block, oldest first
    beat_t             pending_beats[$];
    stim_row_t         dir_rows[$];

    int                err_count;
    int                sent_count;
    int                checked_count;
    int                peak_count;
    int                sat_count;
    int                tx_burst_left;
    int                rx_left;
    rx_mode_t          rx_mode;

    // clock, 8 ns period
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #(TIMEOUT_NS);
        $display("tb_top: errors");
        $finish;
    end

    // square the sample, look for a peak on the previous square, update rings,
    // threshold and rate, then shift the history
    function automatic beat_t detect_beat(input logic signed [SMP_W-1:0] s);
        beat_t             res;
        longint            mag;
        longint            acc;
        longint            quot;
        logic [AMP_W-1:0]  cur;
        logic [POS_W-1:0]  pk_pos;
        logic [POS_W-1:0]  span;
        int                nxt;
        mag = longint'(s);
        if (mag < 0)
            mag = -mag;
        cur = AMP_W'(mag * mag);
        res = '0;
        if (cur > thr_lvl && prev_sq > older_sq && prev_sq > cur)
        begin
            // position of the previous sample, wraps at 4096
            pk_pos = pos_cnt - POS_W'(1);
            nxt = (ring_idx + 1) % RING_DEPTH;
            amp_ring[ring_idx] = prev_sq;
            pos_ring[ring_idx] = pk_pos;
            acc = 0;
            for (int i = 0; i < RING_DEPTH; i++)
                acc += longint'(amp_ring[i]);
            thr_lvl = AMP_W'(acc / 10);
            // span from oldest to newest stored position, modulo 4096
            span = pos_ring[ring_idx] - pos_ring[nxt];
            if (span != '0)
            begin
                quot = BPM_NUMERATOR / longint'(span);
                bpm_rate = (quot > RATE_CEIL) ? RATE_MAX : RATE_W'(quot);
            end
            ring_idx = nxt;
            res.found = 1'b1;
            res.amp = prev_sq;
            res.pos = pk_pos;
        end
        older_sq = prev_sq;
        prev_sq = cur;
        pos_cnt = pos_cnt + POS_W'(1);
        res.thr = thr_lvl;
        res.rate = bpm_rate;
        return res;
    endfunction

    // magnitude with a random sign, clipped to the sample range
    function automatic logic signed [SMP_W-1:0] signed_mag(input int mag);
        int v;
        v = ($urandom_range(0, 1) == 1) ? -mag : mag;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return SMP_W'(v);
    endfunction

    // present one sample, wait for acceptance, then queue its expected result;
    // a typed expectation replaces the prediction but the shadow state still advances
    task automatic send_sample(input logic signed [SMP_W-1:0] s, input bit typed_ok,
                               input beat_t typed);
        int    gap;
        beat_t pred;
        // sender bursts: a random gap once the current burst runs out
        if (tx_burst_left == 0)
        begin
            gap = $urandom_range(1, 12);
            tx_burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                        : $urandom_range(1, 30);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        tx_burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        sample <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // beat accepted at this edge
        pred = detect_beat(s);
        pending_beats.push_back(typed_ok ? typed : pred);
        sent_count++;
    endtask

    // hold the sender off until every owed result has come back
    task automatic wait_all_results();
        @(negedge clk);
        in_valid <= 1'b0;
        tx_burst_left = 0;
        while (pending_beats.size() != 0)
            @(posedge clk);
    endtask

    task automatic add_row(input logic signed [SMP_W-1:0] s, input bit typed_ok,
                           input logic f, input logic [AMP_W-1:0] a,
                           input logic [POS_W-1:0] p, input logic [AMP_W-1:0] t,
                           input logic [RATE_W-1:0] r);
        stim_row_t row;
        row.smp = s;
        row.typed_ok = typed_ok;
        row.want = '{found: f, amp: a, pos: p, thr: t, rate: r};
        dir_rows.push_back(row);
    endtask

    // low baseline, rising edge, peak, then a follower just under the peak
    // so that it clears a threshold of about half the mean square
    task automatic send_beat();
        int base_len;
        int lvl;
        int a;
        int f;
        base_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 250)
                                               : $urandom_range(0, 12);
        lvl = 1 << $urandom_range(2, 11);
        repeat (base_len) send_sample(signed_mag($urandom_range(0, lvl)), 1'b0, '0);
        a = ($urandom_range(0, 7) == 0) ? 32768 : $urandom_range(6000, 32767);
        f = a * $urandom_range(72, 99) / 100;
        send_sample(signed_mag(a / 2), 1'b0, '0);
        send_sample(signed_mag(a), 1'b0, '0);
        send_sample(signed_mag(f), 1'b0, '0);
    endtask

    // peak shape that must not fire: a tie after the peak, or a follower under threshold
    task automatic send_broken();
        int a;
        a = $urandom_range(6000, 32767);
        send_sample(signed_mag(a / 2), 1'b0, '0);
        send_sample(signed_mag(a), 1'b0, '0);
        if ($urandom_range(0, 1) == 1)
            send_sample(signed_mag(a), 1'b0, '0);
        else
            send_sample(signed_mag($urandom_range(0, 200)), 1'b0, '0);
    endtask

    // receiver: each stall pattern holds for a random stretch of cycles
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(20, 300);
            end
            rx_left--;
            case (rx_mode)
                RX_FREE:        out_ready <= 1'b1;
                RX_RANDOM:      out_ready <= ($urandom_range(0, 3) != 0);
                RX_EVERY_THIRD: out_ready <= (rx_left % 3 == 0);
                default:        out_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // result checker: compare each accepted beat with the oldest owed result
    always @(posedge clk)
    begin
        beat_t exp_b;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_beats.size() == 0)
            begin
                $error("result beat arrived with nothing owed");
                err_count++;
            end
            else
            begin
                exp_b = pending_beats.pop_front();
                checked_count++;
                if (exp_b.found)
                    peak_count++;
                if (exp_b.rate == RATE_MAX)
                    sat_count++;
                if (peak_found !== exp_b.found)
                begin
                    $error("peak_found: expected %0d, actual %0d", exp_b.found, peak_found);
                    err_count++;
                end
                if (peak_amplitude !== exp_b.amp)
                begin
                    $error("peak_amplitude: expected %0d, actual %0d",
                           exp_b.amp, peak_amplitude);
                    err_count++;
                end
                if (peak_position !== exp_b.pos)
                begin
                    $error("peak_position: expected %0d, actual %0d",
                           exp_b.pos, peak_position);
                    err_count++;
                end
                if (current_threshold !== exp_b.thr)
                begin
                    $error("current_threshold: expected %0d, actual %0d",
                           exp_b.thr, current_threshold);
                    err_count++;
                end
                if (rate_tenths_bpm !== exp_b.rate)
                begin
                    $error("rate_tenths_bpm: expected %0d, actual %0d",
                           exp_b.rate, rate_tenths_bpm);
                    err_count++;
                end
            end
        end
    end

    // main sequence
    initial
    begin
        int pick;
        int stop_at;
        bit quiet_done;
        // inputs known from time zero
        rst_n = 1'b0;
        in_valid = 1'b0;
        sample = '0;
        out_ready = 1'b0;
        err_count = 0;
        sent_count = 0;
        checked_count = 0;
        peak_count = 0;
        sat_count = 0;
        tx_burst_left = 0;
        rx_left = 0;
        rx_mode = RX_FREE;
        quiet_done = 1'b0;
        // shadow state matches the reset state of the block
        prev_sq = '0;
        older_sq = '0;
        pos_cnt = '0;
        thr_lvl = '0;
        ring_idx = 0;
        bpm_rate = '0;
        for (int i = 0; i < RING_DEPTH; i++)
        begin
            amp_ring[i] = '0;
            pos_ring[i] = '0;
        end

        // directed table
        // right after reset: full-scale negative, history reads as zero, no peak
        add_row(-16'sd32768, 1'b1, 1'b0, 31'd0, 12'd0, 31'd0, 16'd0);
        // first peak at position 0, oldest stored position is also 0: zero span holds rate
        add_row(16'sd16384, 1'b1, 1'b1, 31'd1073741824, 12'd0, 31'd107374182, 16'd0);
        add_row(16'sd32767, 1'b1, 1'b0, 31'd0, 12'd0, 31'd107374182, 16'd0);
        // second peak two positions later: span of 2 saturates the rate
        add_row(16'sd20000, 1'b1, 1'b1, 31'd1073676289, 12'd2, 31'd214741811, 16'd65535);
        add_row(-16'sd20001, 1'b0, 1'b0, '0, '0, '0, '0);
        add_row(16'sd0, 1'b0, 1'b0, '0, '0, '0, '0);
        add_row(-16'sd1, 1'b0, 1'b0, '0, '0, '0, '0);
        add_row(16'sd1, 1'b0, 1'b0, '0, '0, '0, '0);
        add_row(16'sd0, 1'b0, 1'b0, '0, '0, '0, '0);
        add_row(16'sd32767, 1'b0, 1'b0, '0, '0, '0, '0);
        // equal square after a high one, no strict maximum
        add_row(-16'sd32767, 1'b0, 1'b0, '0, '0, '0, '0);
        add_row(16'sd25000, 1'b0, 1'b0, '0, '0, '0, '0);
        add_row(-16'sd32768, 1'b0, 1'b0, '0, '0, '0, '0);
        add_row(16'sd30000, 1'b0, 1'b0, '0, '0, '0, '0);
        add_row(16'sd100, 1'b0, 1'b0, '0, '0, '0, '0);
        add_row(16'sd32767, 1'b0, 1'b0, '0, '0, '0, '0);
        // local maximum but the follower sits under the threshold
        add_row(16'sd5000, 1'b0, 1'b0, '0, '0, '0, '0);
        add_row(-16'sd16384, 1'b0, 1'b0, '0, '0, '0, '0);
        add_row(-16'sd32767, 1'b0, 1'b0, '0, '0, '0, '0);
        add_row(-16'sd30000, 1'b0, 1'b0, '0, '0, '0, '0);
        add_row(16'sd16384, 1'b0, 1'b0, '0, '0, '0, '0);
        add_row(-16'sd2, 1'b0, 1'b0, '0, '0, '0, '0);

        // hold reset, then release it on a falling edge
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_sample(dir_rows[i].smp, dir_rows[i].typed_ok, dir_rows[i].want);

        // sender pressure: let the block run dry once
        wait_all_results();

        // random part: mostly well-formed beats, some noise and broken shapes
        stop_at = sent_count + RAND_ITEMS + QUIET_LEN;
        while (sent_count < stop_at)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
                send_beat();
            else if (pick < 9)
                repeat ($urandom_range(1, 8))
                    send_sample(SMP_W'($urandom_range(0, 65535)), 1'b0, '0);
            else
                send_broken();
            // halfway: drain, then a long quiet stretch so the next spans are long
            if (!quiet_done && sent_count >= stop_at - QUIET_LEN - RAND_ITEMS / 2)
            begin
                wait_all_results();
                repeat (QUIET_LEN)
                    send_sample(signed_mag($urandom_range(0, 15)), 1'b0, '0);
                quiet_done = 1'b1;
            end
        end

        // end of stimulus: everything back, then a tail for stray beats
        wait_all_results();
        repeat (DRAIN_TAIL) @(posedge clk);

        $display("summary: %0d samples sent, %0d results checked", sent_count, checked_count);
        $display("summary: %0d peaks detected, %0d results with a saturated rate",
                 peak_count, sat_count);
        if (err_count == 0 && pending_beats.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/atpr_pkg.sv
sv/adaptive_threshold_peak_rate_top.sv
sim/tb_top.sv
